// ===== hw/rtl/pbr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbr_pkg
// Types, constants and limits shared by the PackBits row encoder modules.
// ----------------------------------------------------------------------------
package pbr_pkg;

    // Row and run limits
    localparam int unsigned MAX_ROW_BYTES = 32768;
    localparam int unsigned MAX_RUN       = 127;
    localparam int unsigned RUN_LIMIT     = (MAX_RUN < 4) ? 4 : ((MAX_RUN > 128) ? 128 : MAX_RUN);
    localparam int unsigned RUN_W         = $clog2(RUN_LIMIT + 1);

    // Literal limit, run header base and streak length that breaks a literal
    localparam logic [6:0] LIT_LIMIT    = 7'h7f;
    localparam logic [8:0] HDR_BASE     = 9'h101;
    localparam logic [2:0] STREAK_BREAK = 3'd4;

    // Most writes that one item can cause
    localparam int unsigned MAX_RES = 4;
    localparam int unsigned RES_W   = $clog2(MAX_RES + 1);

    // Result queue; depth is a power of two
    localparam int unsigned FIFO_DEPTH = 8;
    localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
    localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_in_row;
    } in_item_t;

    typedef struct packed {
        logic [15:0] write_offset;
        logic [7:0]  write_byte;
        logic        row_done;
        logic [15:0] row_length;
    } out_item_t;

    // Encoder mode
    typedef enum logic [3:0] {
        MODE_EMPTY = 4'b0001,   // row start, nothing held
        MODE_UNIT  = 4'b0010,   // held byte opens a unit
        MODE_RUN   = 4'b0100,   // held byte continues a run
        MODE_LIT   = 4'b1000    // held byte continues a literal
    } mode_t;

    typedef struct packed {
        logic [7:0]       held_byte;
        logic [7:0]       run_value;
        logic [RUN_W-1:0] run_count;
        logic [6:0]       literal_count;
        logic [2:0]       equal_streak;
        logic [15:0]      literal_header_pos;
        logic [15:0]      out_pointer;
        mode_t            mode;
        logic [15:0]      row_bytes;
    } enc_state_t;

    localparam enc_state_t ENC_RESET = '{
        held_byte:          8'd0,
        run_value:          8'd0,
        run_count:          '0,
        literal_count:      7'd0,
        equal_streak:       3'd1,
        literal_header_pos: 16'd0,
        out_pointer:        16'd0,
        mode:               MODE_EMPTY,
        row_bytes:          16'd0
    };

    // Writes caused by one item, in order, with their count
    typedef struct packed {
        out_item_t [MAX_RES-1:0] w;
        logic [RES_W-1:0]        n;
    } wr_list_t;

endpackage
`default_nettype wire

// ===== hw/rtl/pbr_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbr_core
// Encoder state and single-pass logic: turns one registered byte into the
// list of up to four byte writes it causes and the next encoder state.
// ----------------------------------------------------------------------------
module pbr_core (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              advance,
    input  wire pbr_pkg::in_item_t item,
    output pbr_pkg::wr_list_t      wr_list
);

    typedef struct packed {
        pbr_pkg::enc_state_t st;
        pbr_pkg::wr_list_t   wl;
    } step_t;

    pbr_pkg::enc_state_t state_reg;
    pbr_pkg::enc_state_t state_next;
    step_t               step;
    logic [15:0]         row_bytes_inc;
    logic                row_end;

    // Append one write to the list
    function automatic step_t put(step_t s_in, logic [15:0] pos, logic [7:0] val);
        step_t s;
        s = s_in;
        if (s.wl.n < pbr_pkg::RES_W'(pbr_pkg::MAX_RES)) begin
            s.wl.w[s.wl.n[1:0]].write_offset = pos;
            s.wl.w[s.wl.n[1:0]].write_byte   = val;
            s.wl.n                           = s.wl.n + 1'b1;
        end
        return s;
    endfunction

    // Handle byte cur, given whether it equals its successor
    function automatic step_t take(step_t s_in, logic [7:0] cur, logic eqn, logic last);
        step_t      s;
        logic [8:0] hdr;
        logic       brk;
        s   = s_in;
        brk = 1'b0;
        case (s.st.mode)
            pbr_pkg::MODE_RUN: begin
                s.st.run_count = s.st.run_count + 1'b1;
                if (s.st.run_count >= pbr_pkg::RUN_W'(pbr_pkg::RUN_LIMIT) || !eqn || last) begin
                    hdr = pbr_pkg::HDR_BASE - 9'(s.st.run_count);
                    s = put(s, s.st.out_pointer, hdr[7:0]);
                    s.st.out_pointer = s.st.out_pointer + 16'd1;
                    s = put(s, s.st.out_pointer, s.st.run_value);
                    s.st.out_pointer = s.st.out_pointer + 16'd1;
                    s.st.mode = pbr_pkg::MODE_UNIT;
                end
            end
            pbr_pkg::MODE_LIT: begin
                if (eqn) begin
                    s.st.equal_streak = s.st.equal_streak + 3'd1;
                    if (s.st.equal_streak >= pbr_pkg::STREAK_BREAK) begin
                        // retract the streak bytes and reopen them as a run
                        brk = 1'b1;
                        s.st.out_pointer   = s.st.out_pointer - 16'd2;
                        s.st.literal_count = s.st.literal_count - 7'd2;
                        s = put(s, s.st.literal_header_pos,
                                {1'b0, s.st.literal_count - 7'd1});
                        s.st.mode         = pbr_pkg::MODE_RUN;
                        s.st.run_value    = cur;
                        s.st.run_count    = pbr_pkg::RUN_W'(3);
                        s.st.equal_streak = 3'd1;
                    end
                end else begin
                    s.st.equal_streak = 3'd1;
                end
                if (!brk) begin
                    s = put(s, s.st.out_pointer, cur);
                    s.st.out_pointer   = s.st.out_pointer + 16'd1;
                    s.st.literal_count = s.st.literal_count + 7'd1;
                    if (s.st.literal_count >= pbr_pkg::LIT_LIMIT || last) begin
                        s = put(s, s.st.literal_header_pos,
                                {1'b0, s.st.literal_count - 7'd1});
                        s.st.mode = pbr_pkg::MODE_UNIT;
                    end
                end
            end
            default: begin
                // a new unit opens with cur
                if (eqn && !last) begin
                    s.st.mode      = pbr_pkg::MODE_RUN;
                    s.st.run_value = cur;
                    s.st.run_count = pbr_pkg::RUN_W'(1);
                end else begin
                    s.st.literal_header_pos = s.st.out_pointer;
                    s.st.out_pointer        = s.st.out_pointer + 16'd1;
                    s = put(s, s.st.out_pointer, cur);
                    s.st.out_pointer   = s.st.out_pointer + 16'd1;
                    s.st.literal_count = 7'd1;
                    s.st.equal_streak  = 3'd1;
                    s.st.mode          = pbr_pkg::MODE_LIT;
                    if (last) begin
                        s = put(s, s.st.literal_header_pos, 8'd0);
                        s.st.mode = pbr_pkg::MODE_UNIT;
                    end
                end
            end
        endcase
        return s;
    endfunction

    // Count the row and force its end at the row limit
    assign row_bytes_inc = state_reg.row_bytes + 16'd1;
    assign row_end       = item.last_in_row
                         || (row_bytes_inc >= 16'(pbr_pkg::MAX_ROW_BYTES));

    // Settle the held byte, then at a row end the last byte of the row
    always_comb begin
        step.st = state_reg;
        step.wl = '0;
        if (state_reg.mode == pbr_pkg::MODE_EMPTY) begin
            step.st.mode = pbr_pkg::MODE_UNIT;
        end else begin
            step = take(step, state_reg.held_byte,
                        state_reg.held_byte == item.data_byte, 1'b0);
        end
        step.st.held_byte = item.data_byte;
        step.st.row_bytes = row_bytes_inc;
        if (row_end) begin
            step = take(step, item.data_byte, 1'b0, 1'b1);
            if (step.wl.n != '0) begin
                step.wl.w[2'(step.wl.n - 1'b1)].row_done   = 1'b1;
                step.wl.w[2'(step.wl.n - 1'b1)].row_length = step.st.out_pointer;
            end
            step.st = pbr_pkg::ENC_RESET;
        end
    end

    assign state_next = step.st;
    assign wr_list    = step.wl;

    // Advance the encoder state on each item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pbr_pkg::ENC_RESET;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    // A row end always leaves a final write carrying the row length
    a_row_end_writes: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && row_end |-> wr_list.n != '0)
        else $error("row end produced no write");

    // After a row end the encoder restarts at offset zero with nothing held
    a_row_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && row_end |=> state_reg.mode == pbr_pkg::MODE_EMPTY
                               && state_reg.out_pointer == 16'd0
                               && state_reg.row_bytes == 16'd0)
        else $error("encoder did not restart after row end");

    // The encoder mode always holds exactly one state bit
    a_mode_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg.mode))
        else $error("encoder mode not one-hot");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/pbr_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbr_fifo
// Result queue: takes up to four writes per cycle from the encoder and hands
// them out one per cycle on the result channel while the channel is ready.
// ----------------------------------------------------------------------------
module pbr_fifo (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  wire pbr_pkg::wr_list_t  wr_list,
    output logic                    room,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output pbr_pkg::out_item_t      m_item
);

    pbr_pkg::out_item_t               mem_reg [pbr_pkg::FIFO_DEPTH];
    logic [pbr_pkg::PTR_W-1:0]        wr_ptr_reg;
    logic [pbr_pkg::PTR_W-1:0]        wr_ptr_next;
    logic [pbr_pkg::PTR_W-1:0]        rd_ptr_reg;
    logic [pbr_pkg::PTR_W-1:0]        rd_ptr_next;
    logic [pbr_pkg::CNT_W-1:0]        count_reg;
    logic [pbr_pkg::CNT_W-1:0]        count_next;
    logic [pbr_pkg::CNT_W-1:0]        push_n;
    logic                             pop;

    assign pop     = m_valid && m_ready;
    assign push_n  = push ? pbr_pkg::CNT_W'(wr_list.n) : '0;
    assign m_valid = (count_reg != '0);
    assign m_item  = mem_reg[rd_ptr_reg];
    assign room    = (count_reg <= pbr_pkg::CNT_W'(pbr_pkg::FIFO_DEPTH - pbr_pkg::MAX_RES));

    assign wr_ptr_next = wr_ptr_reg + pbr_pkg::PTR_W'(push_n);
    assign rd_ptr_next = rd_ptr_reg + pbr_pkg::PTR_W'(pop);
    assign count_next  = count_reg + push_n - pbr_pkg::CNT_W'(pop);

    // Store the item's writes at consecutive slots
    always_ff @(posedge aclk) begin
        for (int i = 0; i < pbr_pkg::MAX_RES; i++) begin
            if (push && (pbr_pkg::RES_W'(i) < wr_list.n)) begin
                mem_reg[pbr_pkg::PTR_W'(wr_ptr_reg + pbr_pkg::PTR_W'(i))] <= wr_list.w[i];
            end
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    // Occupancy never exceeds the depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= pbr_pkg::CNT_W'(pbr_pkg::FIFO_DEPTH))
        else $error("result queue over depth");

    // A push always fits in the free slots
    a_push_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (pbr_pkg::CNT_W + 1)'(count_reg) + (pbr_pkg::CNT_W + 1)'(wr_list.n)
                 <= (pbr_pkg::CNT_W + 1)'(pbr_pkg::FIFO_DEPTH))
        else $error("result queue overflow");

    // Occupancy and pointers stay in step
    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        pbr_pkg::PTR_W'(wr_ptr_reg - rd_ptr_reg) == pbr_pkg::PTR_W'(count_reg))
        else $error("result queue pointers out of step");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/packbits_row_encoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// packbits_row_encoder
// PackBits encoder for image rows: byte stream in, offset/byte writes out.
// ----------------------------------------------------------------------------
// Each input item is one raw byte, with a mark on the last byte of a row;
// each row is encoded on its own and every result item is one byte write at
// an offset within that row's encoded output. The final write of a row has
// row_done set and carries the encoded row length. A literal's header is
// written when the literal closes, and a literal cut short by a run of four
// equal bytes takes back its last two data bytes, which later writes
// overwrite, so writes must be applied in order. A byte is registered at
// the input and encoded, once the result queue has room, into zero to four
// writes, which go to an eight-entry result queue drained at one write per
// cycle while the result port is ready. An item is accepted every cycle as
// long as items average at most one write each and the result port is
// ready; the queue takes the next item while it has room for four writes,
// so a burst of multi-write items slows input to the one-write-per-cycle
// rate of the result port. The writes of an item pass through the input
// register and the result queue before they are offered on the result port.
// ----------------------------------------------------------------------------
module packbits_row_encoder (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire pbr_pkg::in_item_t  s_item,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output pbr_pkg::out_item_t      m_item
);

    logic               in_valid_reg;
    pbr_pkg::in_item_t  in_item_reg;
    logic               advance;
    logic               room;
    pbr_pkg::wr_list_t  wr_list;

    // Encode the held item once the queue can take all its writes
    assign advance = in_valid_reg && room;
    assign s_ready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
    end

    pbr_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (in_item_reg),
        .wr_list (wr_list)
    );

    pbr_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (advance),
        .wr_list (wr_list),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule
`default_nettype wire
